>>> hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Shared constants, command codes and the double-phase coil pattern table.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default build values
  localparam int PRESCALE_RATIO_DEF = 8;
  localparam int COUNT_WIDTH_DEF    = 16;

  // Field widths
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int COIL_W  = 4;
  localparam int LED_W   = 3;
  localparam int PHASE_W = 2;
  localparam int WORD_W  = 16;
  localparam int TDATA_W = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOP_ON     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHOP_OFF    = 2'd2;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 7'd1;
  localparam logic [BYTE_W-1:0] CHOP_ON_RST     = 8'd32;
  localparam logic [BYTE_W-1:0] CHOP_OFF_RST    = 8'd127;

  // Request kinds carried in tuser
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  // Command codes
  localparam logic [BYTE_W-1:0] CMD_PERIOD16  = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_COUNT     = 8'd2;
  localparam logic [BYTE_W-1:0] CMD_DIRECTION = 8'd3;
  localparam logic [BYTE_W-1:0] CMD_ENABLE    = 8'd4;
  localparam logic [BYTE_W-1:0] CMD_PERIOD8   = 8'd5;

  // Byte value that means forward or enabled
  localparam logic [BYTE_W-1:0] FLAG_ON = 8'd1;

  // Status colours
  localparam logic [LED_W-1:0] LED_REVERSE = 3'd1;
  localparam logic [LED_W-1:0] LED_FORWARD = 3'd2;
  localparam logic [LED_W-1:0] LED_IDLE    = 3'd4;

  // Two coils energised per phase
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      2'd0:    pat = 4'h5;
      2'd1:    pat = 4'h6;
      2'd2:    pat = 4'hA;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

>>> hw/rtl/stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer
// Double-phase unipolar stepper driver: chopper ticks and addressed commands.
// ----------------------------------------------------------------------------
// A request is held in the input stage, its result in the result register on m_tdata.
// Throughput: one request per cycle unless m_tready stalls; the single state-update
// stage between the input register and the result register sets that figure.
// Reset: synchronous, active high; clears motor state, chopper and the
// configuration registers to their defaults and empties both stages.
module stepper_phase_sequencer
  import sps_pkg::*;
#(
  parameter int PRESCALE_RATIO = PRESCALE_RATIO_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: dev_addr[6:0], cmd_code[14:7], data_hi[22:15], data_lo[30:23], zero[31]
  input  logic [TDATA_W-1:0]   s_tdata,
  // s_tuser: func (0 tick, 1 command)
  input  logic                 s_tuser,
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: coil_drive[3:0], led_color[6:4], running[7], phase_now[9:8],
  //          steps_left[25:10], zero[31:26]
  output logic [TDATA_W-1:0]   m_tdata,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int PS_W = (PRESCALE_RATIO > 1) ? $clog2(PRESCALE_RATIO) : 1;
  localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE_RATIO - 1);
  localparam int CW = COUNT_WIDTH;

  // Configuration registers
  logic [ADDR_W-1:0] own_address;
  logic [BYTE_W-1:0] chop_on_count;
  logic [BYTE_W-1:0] chop_off_count;

  // Input stage
  logic              in_valid;
  logic              in_func;
  logic [ADDR_W-1:0] in_addr;
  logic [BYTE_W-1:0] in_code;
  logic [BYTE_W-1:0] in_hi;
  logic [BYTE_W-1:0] in_lo;

  // Result stage
  logic               out_valid;
  logic [TDATA_W-1:0] out_data;

  // Motor state
  logic [PHASE_W-1:0] phase_index,    phase_index_next;
  logic               dir_forward,    dir_forward_next;
  logic               motor_enabled,  motor_enabled_next;
  logic [CW-1:0]      step_counter,   step_counter_next;
  logic [WORD_W-1:0]  step_period,    step_period_next;
  logic [WORD_W-1:0]  step_timer,     step_timer_next;
  logic [PS_W-1:0]    prescale_count, prescale_count_next;
  logic [BYTE_W-1:0]  chop_count,     chop_count_next;
  logic [COIL_W-1:0]  coil_latch,     coil_latch_next;
  logic [LED_W-1:0]   led_latch,      led_latch_next;

  logic               advance;
  logic [WORD_W-1:0]  cmd_word;
  logic [WORD_W-1:0]  timer_inc;
  logic [BYTE_W-1:0]  chop_inc;
  logic               addr_hit;
  logic signed [31:0] count_load;
  logic signed [31:0] count_ext;
  logic [TDATA_W-1:0] result;

  // Handshake: input stage moves on when the result stage is free or drains
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address    <= OWN_ADDRESS_RST;
      chop_on_count  <= CHOP_ON_RST;
      chop_off_count <= CHOP_OFF_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS: own_address    <= cfg_data[ADDR_W-1:0];
        CFG_CHOP_ON:     chop_on_count  <= cfg_data;
        CFG_CHOP_OFF:    chop_off_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture a request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_addr <= s_tdata[6:0];
      in_code <= s_tdata[14:7];
      in_hi   <= s_tdata[22:15];
      in_lo   <= s_tdata[30:23];
    end
  end

  // Next state for one tick or one command
  always_comb begin
    phase_index_next    = phase_index;
    dir_forward_next    = dir_forward;
    motor_enabled_next  = motor_enabled;
    step_counter_next   = step_counter;
    step_period_next    = step_period;
    step_timer_next     = step_timer;
    prescale_count_next = prescale_count;
    chop_count_next     = chop_count;
    coil_latch_next     = coil_latch;
    led_latch_next      = led_latch;

    cmd_word   = {in_hi, in_lo};
    addr_hit   = (in_addr == own_address) || (in_addr == '0);
    count_load = 32'(signed'(cmd_word));
    timer_inc  = step_timer + WORD_W'(1);
    chop_inc   = chop_count + BYTE_W'(1);

    if (in_func == FUNC_TICK) begin
      // Prescaler, then step timer and step event
      if (prescale_count == PS_LAST) begin
        prescale_count_next = '0;
        step_timer_next     = timer_inc;
        if (timer_inc == step_period) begin
          step_timer_next = '0;
          if (motor_enabled) begin
            if (dir_forward) begin
              led_latch_next   = LED_FORWARD;
              phase_index_next = phase_index + PHASE_W'(1);
            end else begin
              led_latch_next   = LED_REVERSE;
              phase_index_next = phase_index - PHASE_W'(1);
            end
            if (step_counter[CW-1]) begin
              motor_enabled_next = 1'b0;
            end
            step_counter_next = step_counter - CW'(1);
          end else begin
            led_latch_next = LED_IDLE;
          end
        end
      end else begin
        prescale_count_next = prescale_count + PS_W'(1);
      end
      // Chopper: latch coils at the on count if enabled, clear at the off count
      chop_count_next = chop_inc;
      if (chop_inc == chop_on_count && motor_enabled_next) begin
        coil_latch_next = coil_latch | coil_pattern(phase_index_next);
      end
      if (chop_inc == chop_off_count) begin
        coil_latch_next = '0;
        chop_count_next = '0;
      end
    end else if (addr_hit) begin
      // Addressed command
      unique case (in_code)
        CMD_PERIOD16:  step_period_next   = cmd_word;
        CMD_COUNT:     step_counter_next  = count_load[CW-1:0];
        CMD_DIRECTION: dir_forward_next   = (in_hi == FLAG_ON);
        CMD_ENABLE:    motor_enabled_next = (in_hi == FLAG_ON);
        CMD_PERIOD8:   step_period_next   = {BYTE_W'(0), in_hi};
        default: ;
      endcase
    end

    // Pack the result
    count_ext = 32'(signed'(step_counter_next));
    result    = {6'd0, count_ext[15:0], phase_index_next, motor_enabled_next,
                 led_latch_next, coil_latch_next};
  end

  // Commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index    <= '0;
      dir_forward    <= 1'b1;
      motor_enabled  <= 1'b0;
      step_counter   <= '0;
      step_period    <= '0;
      step_timer     <= '0;
      prescale_count <= '0;
      chop_count     <= '0;
      coil_latch     <= '0;
      led_latch      <= '0;
    end else if (advance) begin
      phase_index    <= phase_index_next;
      dir_forward    <= dir_forward_next;
      motor_enabled  <= motor_enabled_next;
      step_counter   <= step_counter_next;
      step_period    <= step_period_next;
      step_timer     <= step_timer_next;
      prescale_count <= prescale_count_next;
      chop_count     <= chop_count_next;
      coil_latch     <= coil_latch_next;
      led_latch      <= led_latch_next;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
